// File: sv/led_color_transition_stepper_core_macros.svh
// Assertion macros used by the LED color transition stepper RTL.
`ifndef LED_COLOR_TRANSITION_STEPPER_CORE_MACROS_SVH
`define LED_COLOR_TRANSITION_STEPPER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define LCTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LCTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LCTS_ASSERT_IMP(lbl, ante, cons, msg)
`define LCTS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: sv/lcts_pkg.sv
// Shared constants, types and helper functions of the LED color transition stepper.
package lcts_pkg;

  localparam int NUM_LEDS_DEF   = 256;
  localparam int COLOR_BITS_DEF = 16;

  // configuration port
  localparam int CFG_DW = 16;
  localparam int REG_IW = 1;
  localparam int DUR_W  = 16;
  localparam int ACT_W  = 9;
  localparam logic [REG_IW-1:0] REG_DURATION = 1'b0;
  localparam logic [REG_IW-1:0] REG_ACTIVE   = 1'b1;
  localparam logic [DUR_W-1:0]  DUR_RESET    = 16'd150;
  localparam logic [ACT_W-1:0]  ACT_RESET    = 9'd256;

  // request codes
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // progress fraction, Q16 with 1.0 = 65536
  localparam logic [16:0] K_ONE = 17'd65536;
  localparam logic [16:0] K_MIN = 17'd7;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // shared divider widths
  localparam int DIV_DW = 48;
  localparam int DIV_VW = 32;

  // reciprocals of the exponent denominators, exact below 2^23
  localparam logic [24:0] RCP_FIFTH   = 25'd13421773;
  localparam logic [24:0] RCP_QUARTER = 25'd16777216;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // numerators of the curve exponents 9/10, 3/4, 3/5
  function automatic logic [3:0] exp_num(input logic [1:0] j);
    logic [3:0] v;
    case (j)
      2'd0:    v = 4'd9;
      default: v = 4'd3;
    endcase
    return v;
  endfunction

  // reciprocal multiplier for the exponent denominator
  function automatic logic [24:0] exp_rcp(input logic [1:0] j);
    logic [24:0] v;
    case (j)
      2'd1:    v = RCP_QUARTER;
      default: v = RCP_FIFTH;
    endcase
    return v;
  endfunction

  // shift that goes with the reciprocal; one more halves the fifth into a tenth
  function automatic logic [4:0] exp_sh(input logic [1:0] j);
    logic [4:0] v;
    case (j)
      2'd0:    v = 5'd27;
      default: v = 5'd26;
    endcase
    return v;
  endfunction

endpackage

// File: sv/lcts_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module lcts_div (
  input  logic                          clk,
  input  logic                          rst,
  input  lcts_pkg::div_ctl_t            ctl,
  input  logic [lcts_pkg::DIV_DW-1:0]   dividend,
  input  logic [lcts_pkg::DIV_VW-1:0]   divisor,
  output lcts_pkg::div_sts_t            sts,
  output logic [lcts_pkg::DIV_DW-1:0]   quotient
);
  import lcts_pkg::*;

  localparam int CNT_W = $clog2(DIV_DW + 1);

  logic [DIV_VW-1:0] rem;
  logic [DIV_VW-1:0] dsr;
  logic [DIV_DW-1:0] quo;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;
  logic [DIV_VW:0]   trial;
  logic              fits;

  // shift in the next dividend bit and test against the divisor
  assign trial = {rem, quo[DIV_DW-1]};
  assign fits  = trial >= {1'b0, dsr};

  // sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend and quotient share the shift register
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? DIV_VW'(trial - {1'b0, dsr}) : trial[DIV_VW-1:0];
      quo <= {quo[DIV_DW-2:0], fits};
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign quotient = quo;

endmodule

// File: sv/led_color_transition_stepper_core.sv
// A read goes through S_RD and S_OUT to the output register; a load or a settled tick first passes S_LOAD or S_TK0.
// A moving tick runs the progress divide on the divider, then three power curves (a reciprocal
// multiply and 16 multiply steps each) and a walk that snaps or moves each LED; curves and walk
// use one shared 32x32 multiplier. One item is in work
// at a time; the next transfer is taken while the previous result waits in the output register.
// Reset (sync, active high): first the colors are cleared, then the square-root table is built.
`include "led_color_transition_stepper_core_macros.svh"
module led_color_transition_stepper_core #(
  parameter int NUM_LEDS   = lcts_pkg::NUM_LEDS_DEF,
  parameter int COLOR_BITS = lcts_pkg::COLOR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lcts_pkg::REG_IW-1:0]   cfg_addr,
  input  logic [lcts_pkg::CFG_DW-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    req_type,
  input  logic [7:0]                    led_index,
  input  logic [15:0]                   red_in,
  input  logic [15:0]                   green_in,
  input  logic [15:0]                   blue_in,
  input  logic [31:0]                   time_ms,
  input  logic                          snap,
  input  logic                          batch_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   red_out,
  output logic [15:0]                   green_out,
  output logic [15:0]                   blue_out,
  output logic                          all_settled
);
  import lcts_pkg::*;

  localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int CW = $clog2(NUM_LEDS + 1);
  localparam int CB = COLOR_BITS;
  localparam int RW = 3 * CB;
  localparam int GW = CB + 12;
  localparam logic [GW-1:0] TH_TINY = GW'(1) << CB;
  localparam logic [GW-1:0] TH_16   = GW'(16) << CB;
  localparam logic [GW-1:0] TH_32   = GW'(32) << CB;
  localparam logic [GW-1:0] TH_60   = GW'(60) << CB;

  typedef enum logic [18:0] {
    S_CLR  = 19'h00001,
    S_SQ   = 19'h00002,
    S_IDLE = 19'h00004,
    S_LOAD = 19'h00008,
    S_TK0  = 19'h00010,
    S_KDIV = 19'h00020,
    S_NORM = 19'h00040,
    S_LOG  = 19'h00080,
    S_PST  = 19'h00100,
    S_EXP  = 19'h00400,
    S_KPW  = 19'h00800,
    S_WRD  = 19'h01000,
    S_WGAP = 19'h02000,
    S_WMUL = 19'h04000,
    S_WWR  = 19'h08000,
    S_WEND = 19'h10000,
    S_RD   = 19'h20000,
    S_OUT  = 19'h40000
  } state_t;

  state_t state;

  // captured item
  logic [1:0]    req_r;
  logic [7:0]    led_r;
  logic [RW-1:0] col_in_r;
  logic [31:0]   t_r;
  logic          snap_r;
  logic          last_r;

  // configuration and timing state
  logic [DUR_W-1:0] dur_r;
  logic [ACT_W-1:0] act_r;
  logic [31:0]      anim_start;
  logic [31:0]      anim_end;
  logic [31:0]      last_tick;
  logic             settled;

  // power-curve datapath
  logic [16:0] m_r;
  logic [3:0]  n_r;
  logic [15:0] f_r;
  logic [30:0] z_r;
  logic [3:0]  li_r;
  logic [16:0] kp [4];
  logic [1:0]  j_r;
  logic [23:0] p_r;
  logic [30:0] acc_r;
  logic [3:0]  ei_r;

  // square-root table build
  logic [29:0] s_tab [16];
  logic [3:0]  sq_i;
  logic [4:0]  sq_b;
  logic [29:0] sq_r;
  logic [59:0] sq_v;
  logic [29:0] cand;
  logic        sq_fit;
  logic [29:0] sq_root;
  logic [AW-1:0] clr_cnt;

  // LED walk
  logic [CW-1:0] widx;
  logic [CW-1:0] widx_inc;
  logic [CW-1:0] wlim;
  logic          wlast;
  logic          moving;
  logic [16:0]   kp_sel;
  logic [CB-1:0] gap_r [3];
  logic [CB-1:0] col_r [3];
  logic [2:0]    up_r;
  logic [1:0]    ch_r;
  state_t        wstart;

  // walk compare logic
  logic [CB-1:0] cv [3];
  logic [CB-1:0] tv [3];
  logic [CB-1:0] gp [3];
  logic [2:0]    upc;
  logic [CB-1:0] g;
  logic [GW-1:0] gw;
  logic [GW-1:0] g255;
  logic          tiny;
  logic [1:0]    sel;
  logic [CB-1:0] mag;
  logic [CB-1:0] ch_new;

  // memories
  logic [RW-1:0] cur_mem [NUM_LEDS];
  logic [RW-1:0] tgt_mem [NUM_LEDS];
  logic [RW-1:0] cur_rd;
  logic [RW-1:0] tgt_rd;
  logic          cur_we;
  logic [AW-1:0] cur_wa;
  logic [RW-1:0] cur_wd;
  logic          cur_re;
  logic [AW-1:0] cur_ra;
  logic          tgt_we;
  logic          tgt_re;
  logic [AW-1:0] led_a;
  logic          led_ok;

  // timing math
  logic [31:0]   d_last;
  logic          resume;
  logic [31:0]   start_t;
  logic [31:0]   dur_eff;
  logic [31:0]   e_v;
  logic [31:0]   t_tot;
  logic          e_le0;
  logic          e_full;
  logic [16:0]   k_div;
  logic [19:0]   base;
  logic [47:0]   p_dvd;
  logic [23:0]   p_quo;
  logic [7:0]    q_p;
  logic [5:0]    sh_p;
  logic [16:0]   kp_fin;

  // shared multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [31:0] log_sq;
  logic [30:0] log_z;

  // divider
  div_ctl_t          div_ctl;
  div_sts_t          div_sts;
  logic [DIV_DW-1:0] div_dvd;
  logic [DIV_VW-1:0] div_dsr;
  logic [DIV_DW-1:0] div_q;

  logic out_load;

  assign in_ready = (state == S_IDLE);
  assign led_a    = AW'(led_r);
  assign led_ok   = 32'(led_r) < NUM_LEDS;

  // timing setup and progress terms
  assign d_last  = t_r - last_tick;
  assign resume  = !settled && (d_last != 32'd0) && !d_last[31];
  assign start_t = resume ? last_tick : t_r;
  assign dur_eff = (dur_r == '0) ? 32'd1 : 32'(dur_r);
  assign e_v     = t_r - anim_start;
  assign t_tot   = anim_end - anim_start;
  assign e_le0   = (e_v == 32'd0) || e_v[31];
  assign e_full  = (t_tot == 32'd0) || (e_v >= t_tot);
  assign k_div   = (div_q[16:0] < K_MIN) ? K_MIN : div_q[16:0];

  // exponent scaling of the log and the power finish
  assign base   = {n_r, 16'b0} - {4'b0, f_r};
  assign p_dvd  = 48'(base) * 48'(exp_num(j_r));
  assign p_quo  = 24'(mul_p >> exp_sh(j_r));
  assign q_p    = p_r[23:16];
  assign sh_p   = 6'd14 + q_p[5:0];
  assign kp_fin = (q_p >= 8'd31) ? 17'd0 : 17'(acc_r >> sh_p);

  // square-root step
  assign cand    = sq_r | (30'(1) << sq_b);
  assign sq_fit  = mul_p <= {4'b0, sq_v};
  assign sq_root = sq_fit ? cand : sq_r;

  // walk bounds
  assign wlim     = (32'(act_r) > 32'(NUM_LEDS)) ? CW'(NUM_LEDS) : CW'(act_r);
  assign widx_inc = widx + 1'b1;
  assign wlast    = (widx_inc == wlim);
  assign wstart   = (wlim == '0) ? S_WEND : S_WRD;

  // select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQ: begin
        mul_a = 32'(cand);
        mul_b = 32'(cand);
      end
      S_LOG: begin
        mul_a = 32'(z_r);
        mul_b = 32'(z_r);
      end
      S_PST: begin
        mul_a = 32'(p_dvd[23:0]);
        mul_b = 32'(exp_rcp(j_r));
      end
      S_EXP: begin
        mul_a = 32'(acc_r);
        mul_b = 32'(s_tab[ei_r]);
      end
      S_WMUL: begin
        mul_a = 32'(kp_sel);
        mul_b = 32'(gap_r[ch_r]);
      end
      default: ;
    endcase
  end

  assign mul_p  = {32'b0, mul_a} * {32'b0, mul_b};
  assign log_sq = mul_p[61:30];
  assign log_z  = log_sq[31] ? log_sq[31:1] : log_sq[30:0];
  assign mag    = mul_p[16 +: CB];
  assign ch_new = up_r[ch_r] ? col_r[ch_r] + mag : col_r[ch_r] - mag;

  // gaps of one LED and its curve choice
  always_comb begin
    g = '0;
    for (int c = 0; c < 3; c++) begin
      cv[c]  = cur_rd[c*CB +: CB];
      tv[c]  = tgt_rd[c*CB +: CB];
      upc[c] = tv[c] >= cv[c];
      gp[c]  = upc[c] ? tv[c] - cv[c] : cv[c] - tv[c];
      if (gp[c] > g) begin
        g = gp[c];
      end
    end
    gw   = GW'(g);
    tiny = (gw * GW'(1275)) < TH_TINY;
    g255 = gw * GW'(255);
    if (g255 < TH_16) begin
      sel = 2'd3;
    end else if (g255 < TH_32) begin
      sel = 2'd2;
    end else if (g255 < TH_60) begin
      sel = 2'd1;
    end else begin
      sel = 2'd0;
    end
  end

  // divider operands
  assign div_ctl.start = (state == S_TK0) && !settled && !e_le0 && !e_full;
  assign div_dvd       = {e_v, 16'b0};
  assign div_dsr       = t_tot;

  lcts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .sts      (div_sts),
    .quotient (div_q)
  );

  // memory port control
  always_comb begin
    cur_we = 1'b0;
    cur_wa = widx[AW-1:0];
    cur_wd = tgt_rd;
    cur_re = 1'b0;
    cur_ra = widx[AW-1:0];
    tgt_we = 1'b0;
    tgt_re = 1'b0;
    case (state)
      S_CLR: begin
        cur_we = 1'b1;
        cur_wa = clr_cnt;
        cur_wd = '0;
      end
      S_LOAD: begin
        cur_we = snap_r && led_ok;
        cur_wa = led_a;
        cur_wd = col_in_r;
        tgt_we = led_ok;
      end
      S_WGAP: cur_we = tiny;
      S_WWR: begin
        cur_we = 1'b1;
        cur_wd = {col_r[2], col_r[1], col_r[0]};
      end
      S_WRD: begin
        cur_re = 1'b1;
        tgt_re = 1'b1;
      end
      S_RD: begin
        cur_re = 1'b1;
        cur_ra = led_a;
      end
      default: ;
    endcase
  end

  // color memories
  always_ff @(posedge clk) begin
    if (cur_we) begin
      cur_mem[cur_wa] <= cur_wd;
    end
    if (cur_re) begin
      cur_rd <= cur_mem[cur_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (tgt_we) begin
      tgt_mem[led_a] <= col_in_r;
    end
    if (tgt_re) begin
      tgt_rd <= tgt_mem[widx[AW-1:0]];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dur_r <= DUR_RESET;
      act_r <= ACT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DURATION: dur_r <= cfg_wdata[DUR_W-1:0];
        REG_ACTIVE:   act_r <= cfg_wdata[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_cnt    <= '0;
      settled    <= 1'b1;
      anim_start <= '0;
      anim_end   <= '0;
      last_tick  <= '0;
      sq_i       <= '0;
      sq_b       <= 5'd29;
      sq_r       <= '0;
      sq_v       <= 60'(1) << 59;
    end else begin
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(NUM_LEDS - 1)) begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (sq_b == 5'd0) begin
            s_tab[sq_i] <= sq_root;
            sq_v        <= {sq_root, 30'b0};
            sq_r        <= '0;
            sq_b        <= 5'd29;
            sq_i        <= sq_i + 1'b1;
            if (sq_i == 4'd15) begin
              state <= S_IDLE;
            end
          end else begin
            sq_r <= sq_root;
            sq_b <= sq_b - 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req_r    <= req_type;
            led_r    <= led_index;
            col_in_r <= {CB'(blue_in), CB'(green_in), CB'(red_in)};
            t_r      <= time_ms;
            snap_r   <= snap;
            last_r   <= batch_last;
            case (req_type)
              REQ_LOAD: state <= S_LOAD;
              REQ_TICK: state <= S_TK0;
              default:  state <= S_RD;
            endcase
          end
        end
        S_LOAD: begin
          if (last_r) begin
            anim_start <= start_t;
            anim_end   <= start_t + dur_eff;
            if (snap_r) begin
              last_tick <= start_t;
              settled   <= 1'b1;
            end else begin
              settled <= 1'b0;
            end
          end
          state <= S_RD;
        end
        S_TK0: begin
          if (settled) begin
            state <= S_RD;
          end else begin
            last_tick <= t_r;
            if (e_le0) begin
              kp[0] <= K_MIN;
              m_r   <= K_MIN;
              n_r   <= '0;
              state <= S_NORM;
            end else if (e_full) begin
              for (int i = 0; i < 4; i++) begin
                kp[i] <= K_ONE;
              end
              widx   <= '0;
              moving <= 1'b0;
              state  <= wstart;
            end else begin
              state <= S_KDIV;
            end
          end
        end
        S_KDIV: begin
          if (div_sts.done) begin
            kp[0] <= k_div;
            m_r   <= k_div;
            n_r   <= '0;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (m_r[16]) begin
            z_r   <= {m_r, 14'b0};
            f_r   <= '0;
            li_r  <= '0;
            state <= S_LOG;
          end else begin
            m_r <= m_r << 1;
            n_r <= n_r + 1'b1;
          end
        end
        S_LOG: begin
          z_r  <= log_z;
          f_r  <= {f_r[14:0], log_sq[31]};
          li_r <= li_r + 1'b1;
          if (li_r == 4'd15) begin
            j_r   <= '0;
            state <= S_PST;
          end
        end
        // scale the log by the exponent with a reciprocal multiply
        S_PST: begin
          p_r   <= p_quo;
          acc_r <= Q30_ONE;
          ei_r  <= '0;
          state <= S_EXP;
        end
        S_EXP: begin
          if (p_r[4'd15 - ei_r]) begin
            acc_r <= mul_p[60:30];
          end
          ei_r <= ei_r + 1'b1;
          if (ei_r == 4'd15) begin
            state <= S_KPW;
          end
        end
        S_KPW: begin
          kp[2'(j_r + 2'd1)] <= kp_fin;
          if (j_r == 2'd2) begin
            widx   <= '0;
            moving <= 1'b0;
            state  <= wstart;
          end else begin
            j_r   <= j_r + 1'b1;
            state <= S_PST;
          end
        end
        S_WRD: state <= S_WGAP;
        S_WGAP: begin
          if (tiny) begin
            widx  <= widx_inc;
            state <= wlast ? S_WEND : S_WRD;
          end else begin
            moving <= 1'b1;
            kp_sel <= kp[sel];
            for (int c = 0; c < 3; c++) begin
              gap_r[c] <= gp[c];
              col_r[c] <= cv[c];
            end
            up_r  <= upc;
            ch_r  <= '0;
            state <= S_WMUL;
          end
        end
        S_WMUL: begin
          col_r[ch_r] <= ch_new;
          ch_r        <= ch_r + 1'b1;
          if (ch_r == 2'd2) begin
            state <= S_WWR;
          end
        end
        S_WWR: begin
          widx  <= widx_inc;
          state <= wlast ? S_WEND : S_WRD;
        end
        S_WEND: begin
          settled <= !moving;
          state   <= S_RD;
        end
        S_RD: state <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register: take the result when the slot is free or is being emptied
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      red_out     <= led_ok ? 16'(cur_rd[0 +: CB]) : 16'd0;
      green_out   <= led_ok ? 16'(cur_rd[CB +: CB]) : 16'd0;
      blue_out    <= led_ok ? 16'(cur_rd[2*CB +: CB]) : 16'd0;
      all_settled <= settled;
    end
  end

  // checks
  `LCTS_ASSERT_IMP(a_div_idle, div_ctl.start, !div_sts.busy, "divider restarted while busy")
  `LCTS_ASSERT_IMP(a_walk_bound, state == S_WRD, widx < wlim, "walk index past LED limit")
  `LCTS_ASSERT_IMP(a_kp_range, state == S_WMUL, kp_sel <= K_ONE, "curve factor above one")
  `LCTS_ASSERT_NXT(a_settle, state == S_WEND, settled == !$past(moving), "settled flag mismatch")

endmodule
